// ===== src/kmvcd_pkg.sv =====
// Package for the key matrix vote and change detector.
// Holds the transfer payload types, the sequencer state type and fixed constants.
// No dependencies.
package kmvcd_pkg;

    localparam int SAMPLE_W      = 15;
    localparam int ROW_NUM_W     = 3;
    localparam int HASH_W        = 64;
    localparam int HASH_SHIFT_LO = 6;
    localparam int HASH_SHIFT_HI = 16;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_first;
        logic [SAMPLE_W-1:0] sample_second;
        logic [SAMPLE_W-1:0] sample_third;
    } kmvcd_in_t;

    typedef struct packed {
        logic [ROW_NUM_W-1:0] row_number;
        logic [SAMPLE_W-1:0]  voted_keys;
        logic                 frame_end;
        logic [HASH_W-1:0]    frame_hash;
        logic                 frame_changed;
    } kmvcd_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HASH,
        ST_FINISH
    } kmvcd_state_t;

endpackage

// ===== src/kmvcd_hash_step.sv =====
// One sdbm hash step: h' = bit + (h << 6) + (h << 16) - h, modulo 2^64.
// Depends on kmvcd_pkg for the hash width and shift amounts.
module kmvcd_hash_step
    import kmvcd_pkg::*;
(
    input  logic [HASH_W-1:0] hash_in,
    input  logic              bit_in,
    output logic [HASH_W-1:0] hash_out
);

    logic [HASH_W-1:0] bit_ext;

    assign bit_ext  = HASH_W'(bit_in);
    assign hash_out = bit_ext + (hash_in << HASH_SHIFT_LO) + (hash_in << HASH_SHIFT_HI)
                      - hash_in;

endmodule

// ===== src/key_matrix_vote_change_detect.sv =====
// Top level of the key matrix majority vote and frame change detector.
// Depends on kmvcd_pkg and kmvcd_hash_step.
//
//  Channel | Direction | Ports                       | Payload
//  --------+-----------+-----------------------------+--------------------------
//  s_      | in        | s_valid, s_ready, s_data    | three column samples
//  m_      | out       | m_valid, m_ready, m_data    | row, voted keys, hash, flags
//
// Each row passes through these steps in order: the transfer is taken, each
// column goes through the shared hash step unit in turn, and the frame hash
// is compared and the output register loaded. s_ready is high only while the
// sequencer is idle. Reset (aresetn, synchronous, active low) clears the row
// counter, the running and stored frame hashes and the output valid. If the
// output register still holds an untaken result, the sequencer waits in its
// final state until m_ready frees it.
module key_matrix_vote_change_detect
    import kmvcd_pkg::*;
#(
    parameter int ROW_COUNT    = 8,
    parameter int COLUMN_COUNT = 15
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  kmvcd_in_t  s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output kmvcd_out_t m_data
);

    // Row and column counter widths; at least one bit each.
    localparam int ROW_W = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
    localparam int COL_W = (COLUMN_COUNT > 1) ? $clog2(COLUMN_COUNT) : 1;
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROW_COUNT - 1);
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMN_COUNT - 1);
    // Columns beyond COLUMN_COUNT read as zero in the voted keys.
    localparam logic [SAMPLE_W-1:0] VOTE_MASK =
        (COLUMN_COUNT >= SAMPLE_W) ? {SAMPLE_W{1'b1}}
                                   : SAMPLE_W'((32'd1 << COLUMN_COUNT) - 32'd1);

    kmvcd_state_t state_reg, state_next;

    logic [ROW_W-1:0]    row_reg;
    logic [COL_W-1:0]    col_reg;
    logic [HASH_W-1:0]   hash_reg;
    logic [HASH_W-1:0]   last_hash_reg;
    logic [SAMPLE_W-1:0] vote_reg;
    logic [SAMPLE_W-1:0] shift_reg;
    kmvcd_out_t          out_reg;
    logic                m_valid_reg;

    logic [SAMPLE_W-1:0] vote;
    logic [HASH_W-1:0]   hash_stepped;
    logic                out_free;
    logic                load_item;
    logic                do_step;
    logic                finish;
    logic                last_row;

    // Two-of-three majority per column.
    assign vote = (s_data.sample_first & s_data.sample_second)
                | (s_data.sample_first & s_data.sample_third)
                | (s_data.sample_second & s_data.sample_third);

    // The shared hash unit consumes one column bit per cycle. The shift
    // register runs out of sample bits after the last input column and then
    // feeds zeros, which is what wider matrices hash for missing columns.
    kmvcd_hash_step u_hash_step (
        .hash_in  (hash_reg),
        .bit_in   (shift_reg[0]),
        .hash_out (hash_stepped)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign last_row = (row_reg == LAST_ROW);

    // Sequencer: idle until a transfer arrives, then one hash step per column,
    // then a final state that, once the output is free, compares and publishes.
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        load_item  = 1'b0;
        do_step    = 1'b0;
        finish     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    load_item  = 1'b1;
                    state_next = ST_HASH;
                end
            end
            ST_HASH: begin
                do_step = 1'b1;
                if (col_reg == LAST_COL) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    finish     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Control and state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg       <= '0;
            col_reg       <= '0;
            hash_reg      <= '0;
            last_hash_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (load_item) begin
                col_reg <= '0;
                // The running hash starts over at the first row of a frame.
                if (row_reg == '0) begin
                    hash_reg <= '0;
                end
            end else if (do_step) begin
                col_reg  <= col_reg + COL_W'(1);
                hash_reg <= hash_stepped;
            end

            if (finish) begin
                m_valid_reg <= 1'b1;
                if (last_row) begin
                    last_hash_reg <= hash_reg;
                    row_reg       <= '0;
                end else begin
                    row_reg <= row_reg + ROW_W'(1);
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers; they need no reset.
    always_ff @(posedge aclk) begin
        if (load_item) begin
            vote_reg  <= vote & VOTE_MASK;
            shift_reg <= vote;
        end else if (do_step) begin
            shift_reg <= shift_reg >> 1;
        end

        if (finish) begin
            out_reg.row_number    <= ROW_NUM_W'(row_reg);
            out_reg.voted_keys    <= vote_reg;
            out_reg.frame_end     <= last_row;
            out_reg.frame_hash    <= hash_reg;
            out_reg.frame_changed <= last_row && (hash_reg != last_hash_reg);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

// ===== sim/tb_key_matrix_vote_change_detect.sv =====
// Self-checking testbench for key_matrix_vote_change_detect: row scans in, voted rows out.
// Depends on kmvcd_pkg and the RTL of the block; a behavioral predictor supplies expectations.
`timescale 1ns / 100ps
module tb_key_matrix_vote_change_detect;
    import kmvcd_pkg::*;

    localparam int ROWS      = 8;
    localparam int COLUMNS   = 15;
    localparam int MAX_SHOWN = 10;
    localparam int DRAIN_CYC = 4 * (COLUMNS + 2);
    localparam logic [SAMPLE_W-1:0] ALL_HIGH = '1;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    kmvcd_in_t  s_data = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    kmvcd_out_t m_data;

    // Percentages of cycles in which the sender holds back and the receiver stalls.
    int unsigned src_idle_pct  = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned error_count   = 0;

    // Predictor state, a copy of what the block should hold between rows.
    int unsigned       scan_row_idx = 0;
    logic [HASH_W-1:0] scan_hash = '0;
    logic [HASH_W-1:0] stored_frame_hash = '0;

    // Rows accepted by the block whose results have not come back yet, oldest first.
    kmvcd_out_t pending_rows[$];
    kmvcd_out_t head_row;

    key_matrix_vote_change_detect #(
        .ROW_COUNT   (ROWS),
        .COLUMN_COUNT(COLUMNS)
    ) dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    always #5 aclk = ~aclk;

    // Two-of-three vote per column: a column reads high when at least two samples do.
    function automatic logic [SAMPLE_W-1:0] majority3(input logic [SAMPLE_W-1:0] a,
                                                      input logic [SAMPLE_W-1:0] b,
                                                      input logic [SAMPLE_W-1:0] c);
        return (a & b) | (a & c) | (b & c);
    endfunction

    // Works out the result of one scanned row and advances the predictor state.
    // The hash takes one step per column, column 0 first, and restarts at row 0.
    // On the last row the frame hash is compared with the one kept from the
    // previous frame (zero after reset) and then replaces it.
    function automatic kmvcd_out_t scan_row(input kmvcd_in_t row_in);
        kmvcd_out_t                row_out;
        logic [SAMPLE_W-1:0]       votes;
        logic [HASH_W-1:0]         bit_val;
        logic                      last_row;
        votes = majority3(row_in.sample_first, row_in.sample_second, row_in.sample_third);
        if (scan_row_idx == 0) begin
            scan_hash = '0;
        end
        for (int col = 0; col < COLUMNS; col++) begin
            bit_val   = (col < SAMPLE_W) ? HASH_W'(votes[col]) : '0;
            scan_hash = bit_val + (scan_hash << HASH_SHIFT_LO) + (scan_hash << HASH_SHIFT_HI)
                        - scan_hash;
        end
        if (COLUMNS < SAMPLE_W) begin
            votes &= SAMPLE_W'((1 << COLUMNS) - 1);
        end
        last_row              = (scan_row_idx == ROWS - 1);
        row_out.row_number    = ROW_NUM_W'(scan_row_idx);
        row_out.voted_keys    = votes;
        row_out.frame_end     = last_row;
        row_out.frame_hash    = scan_hash;
        row_out.frame_changed = 1'b0;
        if (last_row) begin
            row_out.frame_changed = (scan_hash != stored_frame_hash);
            stored_frame_hash     = scan_hash;
            scan_row_idx          = 0;
        end else begin
            scan_row_idx = scan_row_idx + 1;
        end
        return row_out;
    endfunction

    // Sends one row. Inputs change only at the falling edge, and the transfer is
    // taken at the first rising edge where s_ready is seen high. Valid stays up
    // after the transfer and drops between rows only when the sender holds back.
    task automatic send_row(input kmvcd_in_t row_in);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= row_in;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_rows.push_back(scan_row(row_in));
    endtask

    task automatic send_samples(input logic [SAMPLE_W-1:0] a, input logic [SAMPLE_W-1:0] b,
                                input logic [SAMPLE_W-1:0] c);
        kmvcd_in_t row_in;
        row_in.sample_first  = a;
        row_in.sample_second = b;
        row_in.sample_third  = c;
        send_row(row_in);
    endtask

    task automatic check_field(input string field, input logic [HASH_W-1:0] want,
                               input logic [HASH_W-1:0] got);
        if (want !== got) begin
            error_count++;
            if (error_count <= MAX_SHOWN) begin
                $display("mismatch in %s: expected 0x%0h, got 0x%0h", field, want, got);
            end
        end
    endtask

    // The receiver drops ready at random, decided at each falling edge.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Every result transfer is checked, field by field, against the oldest pending row.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_rows.size() == 0) begin
                error_count++;
                if (error_count <= MAX_SHOWN) begin
                    $display("result transfer with no row pending: 0x%0h", m_data);
                end
            end else begin
                head_row = pending_rows.pop_front();
                check_field("row_number", HASH_W'(head_row.row_number),
                            HASH_W'(m_data.row_number));
                check_field("voted_keys", HASH_W'(head_row.voted_keys),
                            HASH_W'(m_data.voted_keys));
                check_field("frame_end", HASH_W'(head_row.frame_end),
                            HASH_W'(m_data.frame_end));
                check_field("frame_hash", head_row.frame_hash, m_data.frame_hash);
                check_field("frame_changed", HASH_W'(head_row.frame_changed),
                            HASH_W'(m_data.frame_changed));
            end
        end
    end

    // Three directed frames right after reset. The first has every key released,
    // so its hash is zero and must compare equal to the zero stored at reset.
    // The second presses every key and must report a change; the third repeats
    // it and must not. Within them the samples disagree in every way that still
    // leaves a clear majority, including single samples against the other two.
    task automatic test_directed_frames();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        for (int r = 0; r < ROWS; r++) begin
            case (r % 4)
                0: send_samples('0, '0, '0);
                1: send_samples(ALL_HIGH, '0, '0);
                2: send_samples('0, ALL_HIGH, '0);
                default: send_samples('0, '0, ALL_HIGH);
            endcase
        end
        for (int r = 0; r < ROWS; r++) begin
            case (r % 4)
                0: send_samples(ALL_HIGH, ALL_HIGH, ALL_HIGH);
                1: send_samples('0, ALL_HIGH, ALL_HIGH);
                2: send_samples(ALL_HIGH, '0, ALL_HIGH);
                default: send_samples(ALL_HIGH, ALL_HIGH, '0);
            endcase
        end
        // Same votes as the frame before, reached through mixed bit patterns.
        for (int r = 0; r < ROWS; r++) begin
            case (r % 4)
                0: send_samples(15'h5555, ALL_HIGH, 15'h2AAA);
                1: send_samples(ALL_HIGH, 15'h0F0F, 15'h70F0);
                2: send_samples(15'h00FF, 15'h7F00, ALL_HIGH);
                default: send_samples(ALL_HIGH, ALL_HIGH, ALL_HIGH);
            endcase
        end
    endtask

    // Random whole frames. Half of them repeat the previous frame's votes, a
    // quarter change a single key, the rest are new, so that both outcomes of
    // the frame comparison occur often. Most rows carry the intended votes in
    // two samples with noise in the third; some carry them in all three and some are pure noise.
    task automatic test_random_scan(input int unsigned src_pct, input int unsigned sink_pct,
                                    input int unsigned frames);
        logic [SAMPLE_W-1:0] frame_votes[ROWS];
        logic [SAMPLE_W-1:0] want, noise, a, b, c;
        int unsigned         mode;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        for (int r = 0; r < ROWS; r++) begin
            frame_votes[r] = SAMPLE_W'($urandom);
        end
        for (int f = 0; f < frames; f++) begin
            mode = $urandom_range(3);
            if (mode == 2) begin
                frame_votes[$urandom_range(ROWS - 1)][$urandom_range(SAMPLE_W - 1)] ^= 1'b1;
            end else if (mode == 3) begin
                for (int r = 0; r < ROWS; r++) begin
                    frame_votes[r] = SAMPLE_W'($urandom);
                end
            end
            for (int r = 0; r < ROWS; r++) begin
                want  = frame_votes[r];
                noise = SAMPLE_W'($urandom);
                a = want;
                b = want;
                c = want;
                case ($urandom_range(4))
                    0: a = noise;
                    1: b = noise;
                    2: c = noise;
                    3: begin
                        a = noise;
                        b = SAMPLE_W'($urandom);
                        c = SAMPLE_W'($urandom);
                    end
                    default: ;
                endcase
                send_samples(a, b, c);
                frame_votes[r] = majority3(a, b, c);
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_frames();
        test_random_scan(17, 46, 63);
        test_random_scan(46, 17, 63);
        test_random_scan(0, 0, 63);

        @(negedge aclk);
        s_valid <= 1'b0;
        // Let every pending row come back, then watch a little longer for strays.
        while (pending_rows.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);

        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Hard stop far beyond the slowest correct run.
    initial begin
        #20_000_000;
        $display("timeout with %0d rows still pending", pending_rows.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
